// ===== sv/voxel_face_ao_mesher_assert.svh =====
// assertion macros for the voxel face mesher; clk and rst come from the using module
`ifndef VOXEL_FACE_AO_MESHER_ASSERT_SVH
`define VOXEL_FACE_AO_MESHER_ASSERT_SVH

`ifndef SYNTHESIS

`define VFM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define VFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define VFM_ASSERT_IMPLY(lbl, ante, cons, msg)

`define VFM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/vfm_pkg.sv =====
package vfm_pkg;

  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 4;

  localparam logic [4:0]  CENTRE_BIT    = 5'd13;
  localparam logic [2:0]  VTX_LAST      = 3'd5;
  localparam logic [2:0]  FACE_LAST     = 3'd5;
  localparam logic [1:0]  LEVEL_BRIGHT  = 2'd3;
  localparam logic [23:0] ORDER_DEFAULT = 24'h230120;
  localparam logic [23:0] ORDER_FLIPPED = 24'h231130;

  // neighbor bit index: (dy+1)*9 + (1-dz)*3 + (dx+1)
  localparam logic [4:0] FACING_BIT [NUM_FACES] = '{
    5'd22, 5'd4, 5'd10, 5'd16, 5'd14, 5'd12};

  localparam logic [4:0] SIDE_BIT [NUM_FACES][NUM_CORNERS] = '{
    '{5'd19, 5'd21, 5'd25, 5'd23}, '{5'd7,  5'd3,  5'd1,  5'd5},
    '{5'd19, 5'd11, 5'd1,  5'd9},  '{5'd25, 5'd15, 5'd7,  5'd17},
    '{5'd23, 5'd17, 5'd5,  5'd11}, '{5'd21, 5'd9,  5'd3,  5'd15}};

  localparam logic [4:0] MID_BIT [NUM_FACES][NUM_CORNERS] = '{
    '{5'd20, 5'd18, 5'd24, 5'd26}, '{5'd8,  5'd6,  5'd0,  5'd2},
    '{5'd18, 5'd20, 5'd2,  5'd0},  '{5'd26, 5'd24, 5'd6,  5'd8},
    '{5'd20, 5'd26, 5'd8,  5'd2},  '{5'd24, 5'd18, 5'd0,  5'd6}};

  localparam logic [4:0] FAR_BIT [NUM_FACES][NUM_CORNERS] = '{
    '{5'd23, 5'd19, 5'd21, 5'd25}, '{5'd5,  5'd7,  5'd3,  5'd1},
    '{5'd9,  5'd19, 5'd11, 5'd1},  '{5'd17, 5'd25, 5'd15, 5'd7},
    '{5'd11, 5'd23, 5'd17, 5'd5},  '{5'd15, 5'd21, 5'd9,  5'd3}};

  typedef logic [NUM_CORNERS-1:0][1:0] quad_lvl_t;

  // one voxel after occlusion, handed from the pipe to the emitter
  typedef struct packed {
    logic [NUM_FACES-1:0]            vis;
    logic [NUM_FACES-1:0]            flip;
    logic [NUM_FACES-1:0][NUM_CORNERS-1:0][1:0] lvl;
    logic [3:0]                      x;
    logic [7:0]                      y;
    logic [3:0]                      z;
    logic [15:0]                     tex;
  } vfm_item_t;

  function automatic logic [1:0] corner_level(input logic l, input logic m, input logic r);
    logic [1:0] s;
    s = {1'b0, l} + {1'b0, m} + {1'b0, r};
    return (l && r) ? 2'd0 : LEVEL_BRIGHT - s;
  endfunction

  // true when the quad takes the flipped diagonal
  function automatic logic quad_flip(input quad_lvl_t a);
    logic [1:0] mn;
    logic [1:0] mx;
    logic [1:0] mn_i;
    logic [1:0] mx_i;
    logic [2:0] n;
    logic [1:0] pk;
    mn = 2'd3;
    mx = 2'd0;
    mn_i = 2'd0;
    mx_i = 2'd0;
    n = 3'd0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (a[i] < mn) begin
        mn = a[i];
        mn_i = 2'(i);
        n = 3'd1;
      end else if (a[i] == mn) begin
        n = n + 3'd1;
      end
      if (a[i] > mx) begin
        mx = a[i];
        mx_i = 2'(i);
      end
    end
    pk = (n == 3'd1) ? mn_i : mx_i;
    return !pk[0];
  endfunction

  function automatic logic [2:0] first_set(input logic [NUM_FACES-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  function automatic logic [1:0] order_corner(input logic flip, input logic [2:0] vtx);
    logic [23:0] ord;
    logic [4:0]  sh;
    ord = flip ? ORDER_FLIPPED : ORDER_DEFAULT;
    sh = {vtx, 2'b00};
    return ord[sh +: 2];
  endfunction

endpackage

// ===== sv/vfm_ao_pipe.sv =====
module vfm_ao_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [26:0]         neighbor_mask,
  input  logic [3:0]          pos_x,
  input  logic [7:0]          pos_y,
  input  logic [3:0]          pos_z,
  input  logic [15:0]         texture_base,
  output logic                busy,
  input  logic                item_ready,
  output logic                item_valid,
  output vfm_pkg::vfm_item_t  item
);
  import vfm_pkg::*;

  logic ready1, ready2, ready3;
  logic v1, v2, v3;

  // stage 1: input capture
  logic [26:0] m1;
  logic [3:0]  x1;
  logic [7:0]  y1;
  logic [3:0]  z1;
  logic [15:0] t1;

  // stage 2: corner levels and visible sides
  logic                  c2;
  logic [NUM_FACES-1:0]  vis2;
  logic [NUM_FACES-1:0][NUM_CORNERS-1:0][1:0] lvl2;
  logic [3:0]  x2;
  logic [7:0]  y2;
  logic [3:0]  z2;
  logic [15:0] t2;

  logic [NUM_FACES-1:0]  vis2_next;
  logic [NUM_FACES-1:0][NUM_CORNERS-1:0][1:0] lvl2_next;
  logic [NUM_FACES-1:0]  flip3_next;

  assign ready3 = !v3 || item_ready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign busy   = !ready1;

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      vis2_next[f] = !m1[CENTRE_BIT] || !m1[FACING_BIT[f]];
      for (int c = 0; c < NUM_CORNERS; c++) begin
        lvl2_next[f][c] = m1[CENTRE_BIT]
          ? corner_level(m1[SIDE_BIT[f][c]], m1[MID_BIT[f][c]], m1[FAR_BIT[f][c]])
          : LEVEL_BRIGHT;
      end
    end
  end

  // non-full centre keeps the default diagonal everywhere
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      flip3_next[f] = c2 && quad_flip(lvl2[f]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= start;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start && ready1) begin
      m1 <= neighbor_mask;
      x1 <= pos_x;
      y1 <= pos_y;
      z1 <= pos_z;
      t1 <= texture_base;
    end
    if (v1 && ready2) begin
      c2   <= m1[CENTRE_BIT];
      vis2 <= vis2_next;
      lvl2 <= lvl2_next;
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      t2   <= t1;
    end
    if (v2 && ready3) begin
      item.vis  <= vis2;
      item.flip <= flip3_next;
      item.lvl  <= lvl2;
      item.x    <= x2;
      item.y    <= y2;
      item.z    <= z2;
      item.tex  <= t2;
    end
  end

  assign item_valid = v3;

endmodule

// ===== sv/vfm_emitter.sv =====
module vfm_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  vfm_pkg::vfm_item_t  item,
  output logic                item_ready,
  output logic                strobe,
  output logic [2:0]          face,
  output logic [1:0]          corner,
  output logic [1:0]          light,
  output logic [3:0]          out_x,
  output logic [7:0]          out_y,
  output logic [3:0]          out_z,
  output logic [15:0]         out_texture,
  output logic                last
);
  import vfm_pkg::*;

  `include "voxel_face_ao_mesher_assert.svh"

  logic                 active;
  logic [2:0]           cur;
  logic [2:0]           vtx;
  logic [NUM_FACES-1:0] pending;
  logic [NUM_FACES-1:0] flip;
  logic [NUM_FACES-1:0][NUM_CORNERS-1:0][1:0] lvl;
  logic [3:0]  x;
  logic [7:0]  y;
  logic [3:0]  z;
  logic [15:0] tex;

  logic       done_now;
  logic       load;
  logic [1:0] corner_next;

  assign done_now    = active && (vtx == VTX_LAST) && (pending == '0);
  assign item_ready  = !active || done_now;
  assign load        = item_valid && item_ready;
  assign corner_next = order_corner(flip[cur], vtx);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= active;
      last   <= done_now;
      if (load) begin
        // an item with no visible side just drops out here
        active <= |item.vis;
      end else if (done_now) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      face        <= cur;
      corner      <= corner_next;
      light       <= lvl[cur][corner_next];
      out_x       <= x;
      out_y       <= y;
      out_z       <= z;
      out_texture <= tex;
    end
    if (load) begin
      cur     <= first_set(item.vis);
      pending <= item.vis & (item.vis - 6'd1);
      vtx     <= 3'd0;
      flip    <= item.flip;
      lvl     <= item.lvl;
      x       <= item.x;
      y       <= item.y;
      z       <= item.z;
      tex     <= item.tex;
    end else if (active) begin
      if (vtx == VTX_LAST) begin
        cur     <= first_set(pending);
        pending <= pending & (pending - 6'd1);
        vtx     <= 3'd0;
      end else begin
        vtx <= vtx + 3'd1;
      end
    end
  end

  `VFM_ASSERT_NEXT(a_done_gives_last, done_now, strobe && last, "final vertex not flagged")
  `VFM_ASSERT_NEXT(a_idle_no_beat, !active, !strobe, "beat without an active voxel")
  `VFM_ASSERT_IMPLY(a_face_range, active, cur <= FACE_LAST && vtx <= VTX_LAST, "bad counter")
  `VFM_ASSERT_IMPLY(a_last_on_beat, last, strobe, "last without a beat")

endmodule

// ===== sv/voxel_face_ao_mesher.sv =====
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// voxel in  | start, busy          | neighbor_mask, pos_x, pos_y, pos_z, texture_base
// vertex out| strobe               | face, corner, light, out_x, out_y, out_z,
//           |                      | out_texture, last
//
// a voxel is taken at an edge with start high and busy low; it passes three
// register stages, then the emitter sends one vertex per cycle, six per visible side
// (0 to 36 beats; a voxel with nothing to show gives no beat)
// the first vertex reaches the ports through the pipe stages, the emitter's load and its output registers
// the emitter sets the sustained rate; busy rises only when all stages are full
// rst is synchronous and clears the valid bits; the receiver cannot stall a beat
module voxel_face_ao_mesher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [26:0] neighbor_mask,
  input  logic [3:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [3:0]  pos_z,
  input  logic [15:0] texture_base,
  output logic        strobe,
  output logic [2:0]  face,
  output logic [1:0]  corner,
  output logic [1:0]  light,
  output logic [3:0]  out_x,
  output logic [7:0]  out_y,
  output logic [3:0]  out_z,
  output logic [15:0] out_texture,
  output logic        last
);
  import vfm_pkg::*;

  logic      item_valid;
  logic      item_ready;
  vfm_item_t item;

  vfm_ao_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .neighbor_mask (neighbor_mask),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .texture_base  (texture_base),
    .busy          (busy),
    .item_ready    (item_ready),
    .item_valid    (item_valid),
    .item          (item)
  );

  vfm_emitter u_emit (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .strobe      (strobe),
    .face        (face),
    .corner      (corner),
    .light       (light),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_texture (out_texture),
    .last        (last)
  );

endmodule
